// ----- rtl/barometric_sensor_compensation_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent assertion forms used by the compensation unit.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication
`define BSCU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bscu: same-cycle check failed");

// next-cycle implication
`define BSCU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bscu: next-cycle check failed");

`endif

// ----- rtl/bscu_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometric compensation package
// Types, constants and helper functions shared across the unit.
// ----------------------------------------------------------------------------
package bscu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RawWidth  = 19;
   localparam int unsigned TempWidth = 16;
   localparam int unsigned CntWidth  = 6;

   // register indexes
   localparam logic [2:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [2:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [2:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [2:0] CSR_B1_B2   = 3'd3;
   localparam logic [2:0] CSR_MC_MD   = 3'd4;
   localparam logic [2:0] CSR_OSS     = 3'd5;

   localparam logic [31:0] C_B6_OFFSET = 32'd4000;
   localparam logic [31:0] C_B4_BIAS   = 32'd32768;
   localparam logic [31:0] C_B7_SCALE  = 32'd50000;
   localparam logic [31:0] C_P_K1      = 32'd3038;
   localparam logic [31:0] C_P_K2      = 32'hFFFF_E343; // -7357
   localparam logic [31:0] C_P_K3      = 32'd3791;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_RUN,
      ST_DIV_GO,
      ST_DIV_RUN,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      S_T_X1,
      S_T_DIV,
      S_P_SQ,
      S_P_X1,
      S_P_X2,
      S_P_X1B,
      S_P_X2B,
      S_P_B4,
      S_P_B7,
      S_P_DIV,
      S_P_PP,
      S_P_P1,
      S_P_P2
   } step_type;

   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

endpackage

// ----- rtl/bscu_mul.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add, one multiplier bit per cycle, low 32 bits of the product.
// ----------------------------------------------------------------------------
module bscu_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  bscu_pkg::mul_req_type req,
   output bscu_pkg::mul_rsp_type rsp
);

   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] acc_ff, acc_in;
   logic        busy_ff, busy_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;   // no bits left, stop early
         end else begin
            acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
            a_in   = {a_ff[30:0], 1'b0};
            b_in   = {1'b0, b_ff[31:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done    = busy_ff && (b_ff == '0);
   assign rsp.product = acc_ff;

endmodule

// ----- rtl/bscu_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bscu_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bscu_pkg::div_req_type req,
   output bscu_pkg::div_rsp_type rsp
);

   logic [31:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [bscu_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        done;

   assign shifted = {r_ff, q_ff[31]};
   assign diff    = shifted - {1'b0, d_ff};
   assign done    = busy_ff && (cnt_ff == bscu_pkg::CntWidth'(bscu_pkg::DataWidth));

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         q_in    = req.dividend;
         r_in    = '0;
         d_in    = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         r_in   = diff[32] ? shifted[31:0] : diff[31:0];
         q_in   = {q_ff[30:0], ~diff[32]};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done;
   assign rsp.quotient = q_ff;

endmodule

// ----- rtl/barometric_sensor_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// Barometric sensor compensation unit
// Datasheet temperature and pressure compensation on bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: one beat per raw reading; req_kind 0 = temperature (low 16
//  bits of req_raw_reading), 1 = pressure (all 19 bits).
//  rsp_ channel: exactly one beat per request, in order, with the kind echoed,
//  0.1 degC or Pa, and divide_error set when a divisor came out zero.
//  csr_ port: calibration words and oversampling, written while idle.
//  Arithmetic: all of it runs through one shift-add multiplier (which stops
//  early once no multiplier bits are left) and one restoring divider, each
//  entered through a start state. Temperature: 1 product + 1 quotient.
//  Pressure: 10 products + 1 quotient. A zero divisor ends either early.
//  One request is in flight at a time; req_ready is high while idle.
//  The result register is separate, so a new request may start while the
//  last response beat waits; a stalled rsp_ready holds only the finish step.
//  Reset: synchronous; clears calibration, oversampling, stored B5 and all
//  handshake state. Pressure before any temperature uses B5 = 0.
// ----------------------------------------------------------------------------
`include "barometric_sensor_compensation_unit_assert.svh"

module barometric_sensor_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [18:0] req_raw_reading,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic signed [31:0] rsp_pressure_pa,
   output logic        rsp_divide_error,
   // configuration
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   // --- configuration registers ---
   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bscu_pkg::CSR_AC1_AC2: ac1_ac2_ff <= csr_write_data;
            bscu_pkg::CSR_AC3_AC4: ac3_ac4_ff <= csr_write_data;
            bscu_pkg::CSR_AC5_AC6: ac5_ac6_ff <= csr_write_data;
            bscu_pkg::CSR_B1_B2:   b1_b2_ff   <= csr_write_data;
            bscu_pkg::CSR_MC_MD:   mc_md_ff   <= csr_write_data;
            bscu_pkg::CSR_OSS:     oss_ff     <= csr_write_data[1:0];
            default: ;            // unknown index, dropped
         endcase
      end
   end

   // calibration words, widened to 32 bits
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = bscu_pkg::sx16(ac1_ac2_ff[31:16]);
   assign ac2 = bscu_pkg::sx16(ac1_ac2_ff[15:0]);
   assign ac3 = bscu_pkg::sx16(ac3_ac4_ff[31:16]);
   assign ac4 = {16'd0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5_ac6_ff[15:0]};
   assign b1  = bscu_pkg::sx16(b1_b2_ff[31:16]);
   assign b2  = bscu_pkg::sx16(b1_b2_ff[15:0]);
   assign mc  = bscu_pkg::sx16(mc_md_ff[31:16]);
   assign md  = bscu_pkg::sx16(mc_md_ff[15:0]);

   // --- control and datapath registers ---
   bscu_pkg::state_type state_ff, state_in;
   bscu_pkg::step_type  step_ff, step_in;

   logic        kind_ff, kind_in;
   logic [18:0] raw_ff, raw_in;
   logic [31:0] x1_ff, x1_in;
   logic [31:0] x3_ff, x3_in;     // also holds the temperature divisor
   logic [31:0] sq_ff, sq_in;
   logic [31:0] b3_ff, b3_in;
   logic [31:0] b4_ff, b4_in;
   logic [31:0] p_ff, p_in;       // B7 before the division, then p
   logic [31:0] ti_ff, ti_in;     // stored B5
   logic [15:0] temp_ff, temp_in;
   logic [31:0] press_ff, press_in;
   logic        err_ff, err_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [15:0] rsp_temp_ff;
   logic [31:0] rsp_press_ff;
   logic        rsp_err_ff;

   bscu_pkg::mul_req_type mul_req;
   bscu_pkg::mul_rsp_type mul_rsp;
   bscu_pkg::div_req_type div_req;
   bscu_pkg::div_rsp_type div_rsp;

   bscu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   bscu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // --- shared terms ---
   logic [31:0] prod, quot, b6, mcsh, x1_t, den_t, x3_t, x2_t, b5_t, p_t, sum_t;
   logic [31:0] tround_t;
   logic        req_fire, out_free;

   assign prod     = mul_rsp.product;
   assign quot     = div_rsp.quotient;
   assign b6       = ti_ff - bscu_pkg::C_B6_OFFSET;
   assign mcsh     = {mc[20:0], 11'd0};
   assign x1_t     = bscu_pkg::sra32(prod, 5'd15);
   assign den_t    = x1_t + md;
   assign x3_t     = x1_ff + bscu_pkg::sra32(prod, 5'd11);
   assign x2_t     = (mcsh[31] ^ x3_ff[31]) ? (32'd0 - quot) : quot;
   assign b5_t     = x1_ff + x2_t;
   assign tround_t = bscu_pkg::sra32(b5_t + 32'd8, 5'd4);
   assign sum_t    = x1_ff + bscu_pkg::sra32(prod, 5'd16) + bscu_pkg::C_P_K3;
   assign p_t      = p_ff + bscu_pkg::sra32(sum_t, 5'd4);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bscu_pkg::ST_IDLE: begin
            if (req_valid) state_in = bscu_pkg::ST_MUL_GO;
         end
         bscu_pkg::ST_MUL_GO: begin
            state_in = bscu_pkg::ST_MUL_RUN;
         end
         bscu_pkg::ST_MUL_RUN: begin
            if (mul_rsp.done) begin
               priority if (step_ff == bscu_pkg::S_T_X1) begin
                  state_in = (den_t == '0) ? bscu_pkg::ST_FIN : bscu_pkg::ST_DIV_GO;
               end else if (step_ff == bscu_pkg::S_P_B4) begin
                  state_in = (prod[31:15] == '0) ? bscu_pkg::ST_FIN : bscu_pkg::ST_MUL_GO;
               end else if (step_ff == bscu_pkg::S_P_B7) begin
                  state_in = bscu_pkg::ST_DIV_GO;
               end else if (step_ff == bscu_pkg::S_P_P2) begin
                  state_in = bscu_pkg::ST_FIN;
               end else begin
                  state_in = bscu_pkg::ST_MUL_GO;
               end
            end
         end
         bscu_pkg::ST_DIV_GO: begin
            state_in = bscu_pkg::ST_DIV_RUN;
         end
         bscu_pkg::ST_DIV_RUN: begin
            if (div_rsp.done) begin
               state_in = (step_ff == bscu_pkg::S_T_DIV) ? bscu_pkg::ST_FIN
                                                         : bscu_pkg::ST_MUL_GO;
            end
         end
         bscu_pkg::ST_FIN: begin
            if (out_free) state_in = bscu_pkg::ST_IDLE;
         end
         default: state_in = bscu_pkg::ST_IDLE;
      endcase
   end

   // --- outputs of the sequencer: handshake and operand selection ---
   always_comb begin
      req_ready        = (state_ff == bscu_pkg::ST_IDLE);
      mul_req.start    = (state_ff == bscu_pkg::ST_MUL_GO);
      div_req.start    = (state_ff == bscu_pkg::ST_DIV_GO);
      mul_req.a        = '0;
      mul_req.b        = '0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (step_ff)
         bscu_pkg::S_T_X1: begin
            mul_req.a = {16'd0, raw_ff[15:0]} - ac6;
            mul_req.b = ac5;
         end
         bscu_pkg::S_T_DIV: begin
            div_req.dividend = bscu_pkg::abs32(mcsh);
            div_req.divisor  = bscu_pkg::abs32(x3_ff);
         end
         bscu_pkg::S_P_SQ: begin
            mul_req.a = b6;
            mul_req.b = b6;
         end
         bscu_pkg::S_P_X1: begin
            mul_req.a = b2;
            mul_req.b = sq_ff;
         end
         bscu_pkg::S_P_X2: begin
            mul_req.a = ac2;
            mul_req.b = b6;
         end
         bscu_pkg::S_P_X1B: begin
            mul_req.a = ac3;
            mul_req.b = b6;
         end
         bscu_pkg::S_P_X2B: begin
            mul_req.a = b1;
            mul_req.b = sq_ff;
         end
         bscu_pkg::S_P_B4: begin
            mul_req.a = ac4;
            mul_req.b = x3_ff + bscu_pkg::C_B4_BIAS;
         end
         bscu_pkg::S_P_B7: begin
            mul_req.a = {13'd0, raw_ff} - b3_ff;
            mul_req.b = bscu_pkg::C_B7_SCALE >> oss_ff;
         end
         bscu_pkg::S_P_DIV: begin
            // unsigned split on B7 keeps the doubled dividend in 32 bits
            div_req.dividend = p_ff[31] ? p_ff : {p_ff[30:0], 1'b0};
            div_req.divisor  = b4_ff;
         end
         bscu_pkg::S_P_PP: begin
            mul_req.a = bscu_pkg::sra32(p_ff, 5'd8);
            mul_req.b = bscu_pkg::sra32(p_ff, 5'd8);
         end
         bscu_pkg::S_P_P1: begin
            mul_req.a = x1_ff;
            mul_req.b = bscu_pkg::C_P_K1;
         end
         bscu_pkg::S_P_P2: begin
            mul_req.a = bscu_pkg::C_P_K2;
            mul_req.b = p_ff;
         end
         default: ;
      endcase
   end

   // --- datapath write-back ---
   always_comb begin
      step_in  = step_ff;
      kind_in  = kind_ff;
      raw_in   = raw_ff;
      x1_in    = x1_ff;
      x3_in    = x3_ff;
      sq_in    = sq_ff;
      b3_in    = b3_ff;
      b4_in    = b4_ff;
      p_in     = p_ff;
      ti_in    = ti_ff;
      temp_in  = temp_ff;
      press_in = press_ff;
      err_in   = err_ff;

      if (req_fire) begin
         kind_in  = req_kind;
         raw_in   = req_raw_reading;
         temp_in  = '0;
         press_in = '0;
         err_in   = 1'b0;
         step_in  = req_kind ? bscu_pkg::S_P_SQ : bscu_pkg::S_T_X1;
      end else if (state_ff == bscu_pkg::ST_MUL_RUN && mul_rsp.done) begin
         step_in = bscu_pkg::step_type'(step_ff + 4'd1);
         unique case (step_ff)
            bscu_pkg::S_T_X1: begin
               x1_in = x1_t;
               x3_in = den_t;
               if (den_t == '0) err_in = 1'b1;
            end
            bscu_pkg::S_P_SQ:  sq_in = bscu_pkg::sra32(prod, 5'd12);
            bscu_pkg::S_P_X1:  x1_in = bscu_pkg::sra32(prod, 5'd11);
            bscu_pkg::S_P_X2: begin
               b3_in = bscu_pkg::sra32((((ac1 << 2) + x3_t) << oss_ff) + 32'd2, 5'd2);
            end
            bscu_pkg::S_P_X1B: x1_in = bscu_pkg::sra32(prod, 5'd13);
            bscu_pkg::S_P_X2B: begin
               x3_in = bscu_pkg::sra32(x1_ff + bscu_pkg::sra32(prod, 5'd16) + 32'd2, 5'd2);
            end
            bscu_pkg::S_P_B4: begin
               b4_in = {15'd0, prod[31:15]};
               if (prod[31:15] == '0) err_in = 1'b1;
            end
            bscu_pkg::S_P_B7:  p_in  = prod;
            bscu_pkg::S_P_PP:  x1_in = prod;
            bscu_pkg::S_P_P1:  x1_in = bscu_pkg::sra32(prod, 5'd16);
            bscu_pkg::S_P_P2:  press_in = p_t;
            default: ;
         endcase
      end else if (state_ff == bscu_pkg::ST_DIV_RUN && div_rsp.done) begin
         step_in = bscu_pkg::step_type'(step_ff + 4'd1);
         if (step_ff == bscu_pkg::S_T_DIV) begin
            ti_in   = b5_t;
            temp_in = tround_t[bscu_pkg::TempWidth-1:0];
         end else begin
            p_in = p_ff[31] ? {quot[30:0], 1'b0} : quot;
         end
      end
   end

   // --- result register ---
   logic load_out;
   assign load_out     = (state_ff == bscu_pkg::ST_FIN) && out_free;
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bscu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ti_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ti_ff        <= ti_in;
      end
      step_ff  <= step_in;
      kind_ff  <= kind_in;
      raw_ff   <= raw_in;
      x1_ff    <= x1_in;
      x3_ff    <= x3_in;
      sq_ff    <= sq_in;
      b3_ff    <= b3_in;
      b4_ff    <= b4_in;
      p_ff     <= p_in;
      temp_ff  <= temp_in;
      press_ff <= press_in;
      err_ff   <= err_in;
      if (load_out) begin
         rsp_kind_ff  <= kind_ff;
         rsp_temp_ff  <= temp_ff;
         rsp_press_ff <= press_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = rsp_kind_ff;
   assign rsp_temperature_tenths = rsp_temp_ff;
   assign rsp_pressure_pa        = rsp_press_ff;
   assign rsp_divide_error       = rsp_err_ff;

   // --- assertions ---
   `BSCU_ASSERT_IMP(a_mul_done_in_run, clock, reset, mul_rsp.done,
                    state_ff == bscu_pkg::ST_MUL_RUN)
   `BSCU_ASSERT_IMP(a_div_done_in_run, clock, reset, div_rsp.done,
                    state_ff == bscu_pkg::ST_DIV_RUN)
   `BSCU_ASSERT_IMP(a_div_nonzero, clock, reset, div_req.start,
                    div_req.divisor != '0)
   `BSCU_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_fire,
                    state_ff == bscu_pkg::ST_MUL_GO)

endmodule
